// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file of the RTL folder.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted
`define ASSERT_IMPL(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, off while reset is asserted
`define ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== rtl/core/pw1w_pkg.sv =====
// Package for the pulse-width one-wire sender: phase type, operation codes,
// register indexes and reset values. No dependencies.
package pw1w_pkg;

    localparam int unsigned TickWidth   = 16;
    localparam int unsigned ByteWidth   = 8;
    localparam int unsigned BitCntWidth = 4;
    localparam int unsigned CfgIdxWidth = 2;

    typedef logic [TickWidth-1:0]   ticks_t;
    typedef logic [ByteWidth-1:0]   byte_t;
    typedef logic [BitCntWidth-1:0] bit_cnt_t;
    typedef logic [CfgIdxWidth-1:0] cfg_idx_t;

    // Frame phases
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_START = 2'd1,
        PH_HIGH  = 2'd2,
        PH_LOW   = 2'd3
    } phase_t;

    // Operation codes of an input beat
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_SEND = 1'b1;

    // Configuration register indexes
    localparam cfg_idx_t CFG_START_LOW = 2'd0;
    localparam cfg_idx_t CFG_LONG      = 2'd1;
    localparam cfg_idx_t CFG_SHORT     = 2'd2;

    // Register reset values
    localparam ticks_t START_LOW_RESET = 16'd5000;
    localparam ticks_t LONG_RESET      = 16'd600;
    localparam ticks_t SHORT_RESET     = 16'd200;

    localparam bit_cnt_t BITS_PER_FRAME = 4'd8;

endpackage

// ===== rtl/core/pulse_width_one_wire_sender.sv =====
// Pulse-width one-wire sender: frame sequencer and result register.
// Depends on pw1w_pkg.
//
//   channel  direction  handshake               payload
//   in       in         in_valid / in_ready     operation, data_byte
//   out      out        out_valid / out_ready   line_level, busy_res, accepted, frame_done
//   cfg      in         cfg_wr_en (no wait)     cfg_addr, cfg_wdata
//
// One beat per cycle unless the output stalls: each input beat is processed in the
// cycle it is accepted and its result sits in the output register on the next cycle.
// in_ready is high whenever the output register is empty or being drained.
// A stalled output holds its beat; the sequencer state advances only on accepted beats.
// Reset is asynchronous, active low; the line idles high after reset.
module pulse_width_one_wire_sender (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 operation,
    input  pw1w_pkg::byte_t      data_byte,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 line_level,
    output logic                 busy_res,
    output logic                 accepted,
    output logic                 frame_done,
    input  logic                 cfg_wr_en,
    input  pw1w_pkg::cfg_idx_t   cfg_addr,
    input  pw1w_pkg::ticks_t     cfg_wdata
);
    import pw1w_pkg::*;

    ticks_t   start_low_reg;
    ticks_t   long_reg;
    ticks_t   short_reg;

    phase_t   phase_reg,  phase_next;
    ticks_t   remain_reg, remain_next;
    byte_t    shift_reg,  shift_next;
    bit_cnt_t bits_reg,   bits_next;
    logic     line_reg,   line_next;

    logic     out_valid_reg, out_valid_next;
    logic     level_reg, busy_reg, acc_reg, done_reg;

    logic     in_fire;
    logic     is_tick;
    logic     period_end;
    bit_cnt_t bits_dec;
    logic     acc_now;
    logic     done_now;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;
    assign is_tick  = (operation == OP_TICK);
    assign period_end = (remain_reg <= ticks_t'(1));
    assign bits_dec = bits_reg - bit_cnt_t'(1);

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_low_reg <= START_LOW_RESET;
            long_reg      <= LONG_RESET;
            short_reg     <= SHORT_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                CFG_START_LOW: start_low_reg <= cfg_wdata;
                CFG_LONG:      long_reg      <= cfg_wdata;
                CFG_SHORT:     short_reg     <= cfg_wdata;
                default:       ;
            endcase
        end
    end

    // Next state of the frame sequencer
    always_comb
    begin
        phase_next  = phase_reg;
        remain_next = remain_reg;
        shift_next  = shift_reg;
        bits_next   = bits_reg;
        line_next   = line_reg;
        if (in_fire)
        begin
            if (!is_tick)
            begin
                // Start a frame only from idle; drop requests while busy
                if (phase_reg == PH_IDLE)
                begin
                    shift_next  = data_byte;
                    bits_next   = BITS_PER_FRAME;
                    line_next   = 1'b0;
                    phase_next  = PH_START;
                    remain_next = start_low_reg;
                end
            end
            else if (phase_reg != PH_IDLE)
            begin
                if (!period_end)
                begin
                    remain_next = remain_reg - ticks_t'(1);
                end
                else
                begin
                    case (phase_reg)
                        PH_START:
                        begin
                            line_next   = 1'b1;
                            phase_next  = PH_HIGH;
                            remain_next = shift_reg[0] ? long_reg : short_reg;
                        end
                        PH_HIGH:
                        begin
                            line_next   = 1'b0;
                            phase_next  = PH_LOW;
                            remain_next = shift_reg[0] ? short_reg : long_reg;
                        end
                        PH_LOW:
                        begin
                            shift_next = shift_reg >> 1;
                            bits_next  = bits_dec;
                            line_next  = 1'b1;
                            if (bits_dec == '0)
                            begin
                                phase_next  = PH_IDLE;
                                remain_next = '0;
                            end
                            else
                            begin
                                phase_next  = PH_HIGH;
                                remain_next = shift_reg[1] ? long_reg : short_reg;
                            end
                        end
                        default: ;
                    endcase
                end
            end
        end
    end

    // Status flags of the current beat
    always_comb
    begin
        acc_now  = 1'b0;
        done_now = 1'b0;
        case (phase_reg)
            PH_IDLE:
            begin
                acc_now = !is_tick;
            end
            PH_LOW:
            begin
                done_now = is_tick && period_end && (bits_dec == '0);
            end
            default: ;
        endcase
    end

    // Hold sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            remain_reg <= '0;
            shift_reg  <= '0;
            bits_reg   <= '0;
            line_reg   <= 1'b1;
        end
        else
        begin
            phase_reg  <= phase_next;
            remain_reg <= remain_next;
            shift_reg  <= shift_next;
            bits_reg   <= bits_next;
            line_reg   <= line_next;
        end
    end

    // Keep the result beat until it is taken
    assign out_valid_next = in_fire || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            level_reg <= line_next;
            busy_reg  <= (phase_next != PH_IDLE);
            acc_reg   <= acc_now;
            done_reg  <= done_now;
        end
    end

    assign out_valid  = out_valid_reg;
    assign line_level = level_reg;
    assign busy_res   = busy_reg;
    assign accepted   = acc_reg;
    assign frame_done = done_reg;

endmodule

// ===== rtl/core/pw1w_checker.sv =====
// Port-level checker for the pulse-width one-wire sender, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module pw1w_checker (
    input logic clk,
    input logic rst_n,
    input logic out_valid,
    input logic out_ready,
    input logic line_level,
    input logic busy_res,
    input logic accepted,
    input logic frame_done
);

    // A stalled result beat stays valid and holds its level, busy and done flags
    `ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(line_level) && $stable(busy_res) && $stable(frame_done),
        "result beat changed while stalled")

    // An idle line is high
    `ASSERT_IMPL(a_idle_high, out_valid && !busy_res, line_level,
        "line low while not busy")

    // A started frame is busy and begins low
    `ASSERT_IMPL(a_start_low, out_valid && accepted, busy_res && !line_level && !frame_done,
        "accepted request did not start a low start period")

    // A finished frame leaves the line idle high
    `ASSERT_IMPL(a_done_idle, out_valid && frame_done, line_level && !busy_res,
        "frame end without idle line")

endmodule

bind pulse_width_one_wire_sender pw1w_checker u_pw1w_checker (.*);

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench for pulse_width_one_wire_sender: directed and random tick/send beats,
// scored one result beat per input beat against a line-level predictor.
// Depends on pw1w_pkg and the sender RTL.
module tb_top;
    import pw1w_pkg::*;

    localparam cfg_idx_t CFG_UNUSED  = 2'd3;
    localparam int       IDLE_LIMIT  = 2000;
    localparam int       PHASE_COUNT = 8;
    localparam int       PHASE_BEATS = 100;

    // One result beat as the sender reports it
    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic accepted;
        logic frame_done;
    } line_result_t;

    logic     clk        = 1'b0;
    logic     rst_n      = 1'b0;
    logic     in_valid   = 1'b0;
    logic     in_ready;
    logic     operation  = OP_TICK;
    byte_t    data_byte  = '0;
    logic     out_valid;
    logic     out_ready  = 1'b0;
    logic     line_level;
    logic     busy_res;
    logic     accepted;
    logic     frame_done;
    logic     cfg_wr_en  = 1'b0;
    cfg_idx_t cfg_addr   = CFG_START_LOW;
    ticks_t   cfg_wdata  = '0;

    // Predicted sender state and its period registers
    phase_t   frame_phase = PH_IDLE;
    ticks_t   ticks_left  = '0;
    byte_t    shift_bits  = '0;
    bit_cnt_t bits_to_go  = '0;
    logic     line_now    = 1'b1;
    ticks_t   start_len   = START_LOW_RESET;
    ticks_t   long_len    = LONG_RESET;
    ticks_t   short_len   = SHORT_RESET;

    line_result_t expected_levels[$];
    line_result_t level_due;
    int           fail_count = 0;
    int           burst_left = 0;

    pulse_width_one_wire_sender dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .data_byte  (data_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .line_level (line_level),
        .busy_res   (busy_res),
        .accepted   (accepted),
        .frame_done (frame_done),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Advance the line predictor by one accepted beat and queue its result
    task automatic predict_line(input logic op, input byte_t data);
        line_result_t res;
        res = '0;
        if (op == OP_SEND)
        begin
            if (frame_phase == PH_IDLE)
            begin
                shift_bits   = data;
                bits_to_go   = BITS_PER_FRAME;
                line_now     = 1'b0;
                frame_phase  = PH_START;
                ticks_left   = start_len;
                res.accepted = 1'b1;
            end
        end
        else if (frame_phase != PH_IDLE)
        begin
            // A zero-length period ends on its first tick, like a one-tick period
            if (ticks_left > 1)
                ticks_left = ticks_left - 1'b1;
            else
            begin
                case (frame_phase)
                    PH_START:
                    begin
                        line_now    = 1'b1;
                        frame_phase = PH_HIGH;
                        ticks_left  = shift_bits[0] ? long_len : short_len;
                    end
                    PH_HIGH:
                    begin
                        line_now    = 1'b0;
                        frame_phase = PH_LOW;
                        ticks_left  = shift_bits[0] ? short_len : long_len;
                    end
                    default:
                    begin
                        shift_bits = shift_bits >> 1;
                        bits_to_go = bits_to_go - 1'b1;
                        line_now   = 1'b1;
                        if (bits_to_go == 0)
                        begin
                            frame_phase    = PH_IDLE;
                            ticks_left     = '0;
                            res.frame_done = 1'b1;
                        end
                        else
                        begin
                            frame_phase = PH_HIGH;
                            ticks_left  = shift_bits[0] ? long_len : short_len;
                        end
                    end
                endcase
            end
        end
        res.line_level = line_now;
        res.busy_res   = (frame_phase != PH_IDLE);
        expected_levels.push_back(res);
    endtask

    // Drive one input beat; insert a random gap when the current burst runs out
    task automatic send_beat(input logic op, input byte_t data);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid  <= 1'b1;
        operation <= op;
        data_byte <= data;
        do
            @(posedge clk);
        while (!in_ready);
        predict_line(op, data);
    endtask

    // Drop valid and wait until every queued result beat has come back
    task automatic settle();
        in_valid <= 1'b0;
        while (expected_levels.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Write one period register; the block must be idle
    task automatic write_reg(input cfg_idx_t idx, input ticks_t value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_START_LOW: start_len = value;
            CFG_LONG:      long_len  = value;
            CFG_SHORT:     short_len = value;
            default:       ;
        endcase
    endtask

    task automatic tick_once();
        send_beat(OP_TICK, byte_t'($urandom));
    endtask

    // Tick until the predicted frame has ended
    task automatic run_frame();
        while (frame_phase != PH_IDLE)
            tick_once();
    endtask

    task automatic test_idle_ticks();
        repeat (4) tick_once();
    endtask

    // Reset bit periods under a short start period, a request while busy,
    // and a rewrite in the middle of a frame
    task automatic test_reset_periods();
        settle();
        write_reg(CFG_START_LOW, 16'd4);
        send_beat(OP_SEND, 8'hC3);
        tick_once();
        send_beat(OP_SEND, 8'h3C);
        while (frame_phase != PH_LOW)
            tick_once();
        repeat (3) tick_once();
        settle();
        write_reg(CFG_LONG, 16'd3);
        write_reg(CFG_SHORT, 16'd2);
        run_frame();
    endtask

    task automatic test_unused_index();
        settle();
        write_reg(CFG_START_LOW, 16'd4);
        write_reg(CFG_UNUSED, 16'hFFFF);
        send_beat(OP_SEND, 8'h96);
        run_frame();
    endtask

    task automatic test_zero_periods();
        settle();
        write_reg(CFG_START_LOW, 16'd0);
        write_reg(CFG_LONG, 16'd0);
        write_reg(CFG_SHORT, 16'd0);
        send_beat(OP_SEND, 8'h5A);
        run_frame();
        tick_once();
    endtask

    task automatic test_byte_extremes();
        settle();
        write_reg(CFG_START_LOW, 16'd1);
        write_reg(CFG_LONG, 16'd2);
        write_reg(CFG_SHORT, 16'd1);
        send_beat(OP_SEND, 8'h00);
        tick_once();
        send_beat(OP_SEND, 8'hFF);
        run_frame();
        send_beat(OP_SEND, 8'hFF);
        run_frame();
        send_beat(OP_SEND, 8'h80);
        run_frame();
        send_beat(OP_SEND, 8'h01);
        run_frame();
    endtask

    function automatic ticks_t pick_period(input int top);
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return 16'd1;
        return ticks_t'($urandom_range(1, top));
    endfunction

    // Mostly whole frames with random bytes, plus idle ticks, busy requests and mid-frame period rewrites
    task automatic test_random_traffic();
        int phase_no;
        int counted;
        int roll;
        for (phase_no = 0; phase_no < PHASE_COUNT; phase_no++)
        begin
            settle();
            write_reg(CFG_START_LOW, pick_period(30));
            write_reg(CFG_LONG, pick_period(12));
            write_reg(CFG_SHORT, pick_period(12));
            if ($urandom_range(0, 2) == 0)
                write_reg(CFG_UNUSED, ticks_t'($urandom));
            counted = 0;
            while (counted < PHASE_BEATS)
            begin
                roll = $urandom_range(0, 99);
                if (frame_phase == PH_IDLE)
                begin
                    if (roll < 85)
                    begin
                        send_beat(OP_SEND, byte_t'($urandom));
                        counted++;
                    end
                    else
                        tick_once();
                end
                else if (roll < 4)
                    send_beat(OP_SEND, byte_t'($urandom));
                else if (roll == 99)
                begin
                    // rewrite one period while a frame is running
                    settle();
                    write_reg(cfg_idx_t'($urandom_range(0, 2)), pick_period(12));
                end
                else
                begin
                    tick_once();
                    counted++;
                end
            end
        end
    endtask

    // Largest periods: start a frame, tick into its start period and request while busy
    task automatic test_max_periods();
        settle();
        write_reg(CFG_START_LOW, 16'hFFFF);
        write_reg(CFG_LONG, 16'hFFFF);
        write_reg(CFG_SHORT, 16'hFFFF);
        send_beat(OP_SEND, 8'hA5);
        repeat (80) tick_once();
        send_beat(OP_SEND, 8'h5A);
        tick_once();
    endtask

    // Receiver: switch between no stall, light stall and heavy stall
    initial
    begin : receiver
        int mode;
        forever
        begin
            mode = $urandom_range(0, 2);
            repeat ($urandom_range(50, 300))
            begin
                @(posedge clk);
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= ($urandom_range(0, 3) != 0);
                    default: out_ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    task automatic check_field(input string name, input logic want, input logic got);
        if (got !== want)
        begin
            $error("%s: expected %0b, got %0b", name, want, got);
            fail_count++;
        end
    endtask

    // Score each result beat against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_levels.size() == 0)
            begin
                $error("result beat with no prediction waiting");
                fail_count++;
            end
            else
            begin
                level_due = expected_levels.pop_front();
                check_field("line_level", level_due.line_level, line_level);
                check_field("busy_res", level_due.busy_res, busy_res);
                check_field("accepted", level_due.accepted, accepted);
                check_field("frame_done", level_due.frame_done, frame_done);
            end
        end
    end

    // End the run when no beat moves on either channel for too long
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb_top: errors");
        $finish;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_ticks();
        test_reset_periods();
        test_unused_index();
        test_zero_periods();
        test_byte_extremes();
        test_random_traffic();
        test_max_periods();
        settle();
        repeat (6) @(posedge clk);
        if (expected_levels.size() != 0)
        begin
            $error("%0d predicted result beats never arrived", expected_levels.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/pw1w_pkg.sv
rtl/core/pulse_width_one_wire_sender.sv
rtl/core/pw1w_checker.sv
sim/tb_top.sv
